// ===== src/ssort_pkg.sv =====
// Shared types and constants for the selection sort engine.
// No dependencies; compiled before every other file of the block.
package ssort_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CMP_W   = 11;
    localparam int unsigned SWP_W   = 6;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               last_out;
        logic [CMP_W-1:0]   compare_count;
        logic [SWP_W-1:0]   swap_count;
        logic               overflow;
    } t_out_beat;

endpackage

// ===== src/selection_sort_engine.sv =====
// Selection sort engine: loads a set, sorts it in place, streams it out ascending.
// Load: one beat per cycle. Sort of n elements: one pass per position but the last, each a
// scan of the unsorted range, then a SWAP1 state and, when the minimum moved, a SWAP2 state.
// Output: a setup state (S_EMIT_RD), then one result beat per cycle while i_ready is high.
// Throughput is set by the single read port of the element RAM, one compare a cycle.
// Reset (i_rst_n, synchronous) clears control and counters; RAM contents stay undefined.
module selection_sort_engine #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ssort_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ssort_pkg::t_out_beat o_data
);
    import ssort_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_LOAD     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SWAP1    = 6'b000100,
        S_SWAP2    = 6'b001000,
        S_EMIT_RD  = 6'b010000,
        S_EMIT_OUT = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_k, n_k;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_best, n_best;
    logic [AW-1:0]      r_didx, n_didx;
    logic               r_dv, n_dv;
    logic [VALUE_W-1:0] r_min, n_min;
    logic [VALUE_W-1:0] r_pos_val, n_pos_val;
    logic [CMP_W-1:0]   r_cmp, n_cmp;
    logic [SWP_W-1:0]   r_swp, n_swp;
    logic               r_ovf, n_ovf;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;
    logic               issue;
    logic               out_last;
    logic               in_beat;
    logic               out_beat;
    logic [CW-1:0]      cnt_m1;

    ssort_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_ready  = (r_state == S_LOAD);
    assign o_valid  = (r_state == S_EMIT_OUT);
    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;
    assign cnt_m1   = r_cnt - CW'(1);
    assign out_last = (r_k == cnt_m1);
    assign issue    = (r_state == S_SCAN) && (r_k < r_cnt);

    assign o_data.sorted_value  = rdata;
    assign o_data.last_out      = out_last;
    assign o_data.compare_count = r_cmp;
    assign o_data.swap_count    = r_swp;
    assign o_data.overflow      = r_ovf;

    // RAM port steering
    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = r_min;
        raddr = '0;
        case (r_state)
            S_LOAD: begin
                we    = in_beat && (r_cnt < CW'(DEPTH));
                waddr = r_cnt[AW-1:0];
                wdata = i_data.value;
            end
            S_SCAN: begin
                if (issue) begin
                    raddr = r_k[AW-1:0];
                end
            end
            S_SWAP1: begin
                we    = (r_best != r_pos);
                waddr = r_pos;
                wdata = r_min;
            end
            S_SWAP2: begin
                we    = 1'b1;
                waddr = r_best;
                wdata = r_pos_val;
            end
            S_EMIT_RD: begin
                raddr = r_k[AW-1:0];
            end
            S_EMIT_OUT: begin
                // look ahead so the next beat is ready in the cycle after a take
                if (out_beat && !out_last) begin
                    raddr = r_k[AW-1:0] + AW'(1);
                end else begin
                    raddr = r_k[AW-1:0];
                end
            end
            default: begin
                raddr = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_pos     = r_pos;
        n_best    = r_best;
        n_didx    = r_didx;
        n_dv      = 1'b0;
        n_min     = r_min;
        n_pos_val = r_pos_val;
        n_cmp     = r_cmp;
        n_swp     = r_swp;
        n_ovf     = r_ovf;
        case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    if (r_cnt < CW'(DEPTH)) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_data.last) begin
                        n_pos = '0;
                        n_k   = '0;
                        if (n_cnt >= CW'(2)) begin
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_EMIT_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_k    = r_k + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_k[AW-1:0];
                end
                if (r_dv) begin
                    if (r_didx == r_pos) begin
                        n_pos_val = rdata;
                        n_min     = rdata;
                        n_best    = r_pos;
                    end else begin
                        n_cmp = r_cmp + CMP_W'(1);
                        // keep the first minimum: take only a strictly smaller value
                        if (rdata < r_min) begin
                            n_min  = rdata;
                            n_best = r_didx;
                        end
                    end
                    if (CW'(r_didx) == cnt_m1) begin
                        n_state = S_SWAP1;
                    end
                end
            end
            S_SWAP1, S_SWAP2: begin
                if ((r_state == S_SWAP1) && (r_best != r_pos)) begin
                    n_swp   = r_swp + SWP_W'(1);
                    n_state = S_SWAP2;
                end else begin
                    n_pos = r_pos + AW'(1);
                    if ((CW'(r_pos) + CW'(2)) >= r_cnt) begin
                        n_k     = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_k     = CW'(r_pos) + CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_beat) begin
                    if (out_last) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                        n_k     = '0;
                        n_cmp   = '0;
                        n_swp   = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_k = r_k + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_pos   <= '0;
            r_dv    <= 1'b0;
            r_cmp   <= '0;
            r_swp   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_dv    <= n_dv;
            r_cmp   <= n_cmp;
            r_swp   <= n_swp;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_didx    <= n_didx;
        r_min     <= n_min;
        r_pos_val <= n_pos_val;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output sides open at once");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP2) |-> $past(r_state == S_SWAP1))
        else $error("second swap write without first");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP1) |-> ((r_best >= r_pos) && (CW'(r_best) < r_cnt)))
        else $error("minimum index outside the unsorted range");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && out_last) |=> ((r_state == S_LOAD) && (r_cnt == '0)
            && (r_cmp == '0) && !r_ovf))
        else $error("state not cleared after final beat");

    a_swaps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_swp <= SWP_W'(r_pos)))
        else $error("more swaps than completed passes");

endmodule

// ===== src/ssort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssort_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
